@@ rtl/core/polygon_point_inclusion_area_macros.svh @@
// ----------------------------------------------------------------------------
// Polygon point inclusion and area: assertion macros
// Wrappers for concurrent assertions, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef POLYGON_POINT_INCLUSION_AREA_MACROS_SVH
`define POLYGON_POINT_INCLUSION_AREA_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge while the reset is released.
`define PPIA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on every rising clock edge, reset included.
`define PPIA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PPIA_ASSERT(lbl, clk, rst_n, prop)
`define PPIA_ASSERT_NR(lbl, clk, prop)
`endif

`endif

@@ rtl/core/ppia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon point inclusion and area: package
// Operation codes, fixed widths and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ppia_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned AREA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic box_clear;    // return the bounding box to its empty value
    logic wr_en;        // store a vertex and widen the box
    logic query_start;  // latch the query point and clear the accumulators
    logic rd_en;        // read one vertex from the store
    logic rd_first;     // the read targets vertex zero
    logic close;        // issue the closing edge, last vertex to first
    logic report;       // register the result word
  } ppia_cmd_t;

  typedef struct packed {
    logic pipe_busy;    // some edge is still in flight
  } ppia_stat_t;

endpackage

@@ rtl/core/ppia_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon point inclusion and area: generic RAM
// Single-port memory with one shared address and a registered read.
// ----------------------------------------------------------------------------
module ppia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/core/ppia_ctrl.sv @@
`timescale 1ns / 1ps
`include "polygon_point_inclusion_area_macros.svh"
// ----------------------------------------------------------------------------
// Polygon point inclusion and area: controller
// Decodes operations, keeps the vertex count and sequences the edge walk.
// ----------------------------------------------------------------------------
module ppia_ctrl import ppia_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  localparam int unsigned AW    = $clog2(MAX_VERTICES),
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [OP_W-1:0] operation_i,
  output ppia_cmd_t       cmd_o,
  output logic [AW-1:0]   addr_o,
  input  ppia_stat_t      stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CLOSE,
    S_DRAIN,
    S_REPORT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  logic             accept;
  logic             full;

  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == CNT_W'(MAX_VERTICES));
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    cmd_o  = '0;
    addr_o = count_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_CLEAR:  cmd_o.box_clear   = 1'b1;
            OP_APPEND: cmd_o.wr_en       = !full;
            OP_QUERY:  cmd_o.query_start = 1'b1;
            default:   cmd_o             = '0;
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (idx_q == '0);
        addr_o         = idx_q[AW-1:0];
      end
      S_CLOSE:  cmd_o.close  = 1'b1;
      S_REPORT: cmd_o.report = 1'b1;
      default:  cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_e'(operation_i))
              OP_CLEAR: count_q <= '0;
              OP_APPEND: begin
                if (!full) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                idx_q   <= '0;
                state_q <= (count_q == '0) ? S_REPORT : S_READ;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          idx_q <= idx_q + CNT_W'(1);
          if (idx_q == count_q - CNT_W'(1)) begin
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: state_q <= S_DRAIN;
        S_DRAIN: begin
          // The closing edge is the last one in flight; report once it lands.
          if (!stat_i.pipe_busy) begin
            state_q <= S_REPORT;
          end
        end
        S_REPORT: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  `PPIA_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_VERTICES))
  `PPIA_ASSERT(a_read_in_range, clk_i, rst_ni, (state_q == S_READ) |-> (idx_q < count_q))
  `PPIA_ASSERT(a_walk_closes, clk_i, rst_ni, (state_q == S_CLOSE) |=> stat_i.pipe_busy)

endmodule

@@ rtl/core/ppia_dp.sv @@
`timescale 1ns / 1ps
`include "polygon_point_inclusion_area_macros.svh"
// ----------------------------------------------------------------------------
// Polygon point inclusion and area: datapath
// Vertex store, bounding box, edge pipeline and result registers.
// ----------------------------------------------------------------------------
module ppia_dp import ppia_pkg::*; #(
  parameter int unsigned COORD_BITS   = 16,
  parameter int unsigned MAX_VERTICES = 64,
  localparam int unsigned AW = $clog2(MAX_VERTICES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppia_cmd_t                    cmd_i,
  input  logic [AW-1:0]                addr_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output ppia_stat_t                   stat_o,
  output logic                         done_o,
  output logic                         inside_res_o,
  output logic signed [AREA_W-1:0]     twice_area_o,
  output logic signed [COORD_BITS-1:0] min_x_o,
  output logic signed [COORD_BITS-1:0] max_x_o,
  output logic signed [COORD_BITS-1:0] min_y_o,
  output logic signed [COORD_BITS-1:0] max_y_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW    = CB + 1;          // coordinate difference
  localparam int unsigned PW    = 2 * CB;          // vertex product
  localparam int unsigned DPW   = 2 * DW;          // difference product
  localparam int unsigned TW    = PW + 1;          // shoelace term
  localparam int unsigned XW    = DPW + 1;         // cross product
  localparam int unsigned SUM_W = TW + CNT_W;
  localparam int unsigned ACC_W = (SUM_W > AREA_W) ? SUM_W : AREA_W;

  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  // Vertex store, y in the upper half of the word.
  logic [2*CB-1:0]      rd_data;
  logic signed [CB-1:0] rd_x, rd_y;

  ppia_ram #(
    .WIDTH(2 * CB),
    .DEPTH(MAX_VERTICES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .addr_i (addr_i),
    .wdata_i({coord_y_i, coord_x_i}),
    .rdata_o(rd_data)
  );

  assign rd_x = signed'(rd_data[CB-1:0]);
  assign rd_y = signed'(rd_data[2*CB-1:CB]);

  // Bounding box.
  logic signed [CB-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= C_MAX;
      max_x_q <= C_MIN;
      min_y_q <= C_MAX;
      max_y_q <= C_MIN;
    end else if (cmd_i.box_clear) begin
      min_x_q <= C_MAX;
      max_x_q <= C_MIN;
      min_y_q <= C_MAX;
      max_y_q <= C_MIN;
    end else if (cmd_i.wr_en) begin
      if (coord_x_i < min_x_q) min_x_q <= coord_x_i;
      if (coord_x_i > max_x_q) max_x_q <= coord_x_i;
      if (coord_y_i < min_y_q) min_y_q <= coord_y_i;
      if (coord_y_i > max_y_q) max_y_q <= coord_y_i;
    end
  end

  // Read data arrives in the cycle after the command.
  logic rdv_q, first_q, close_q;
  logic signed [CB-1:0] px_q, py_q;
  logic signed [CB-1:0] fx_q, fy_q, vx_q, vy_q;

  // Edge stages: s0 endpoints, s1 differences and order, s2 products,
  // s3 shoelace term and cross product.
  logic                  s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic signed [CB-1:0]  s0_ax_q, s0_ay_q, s0_bx_q, s0_by_q;
  logic signed [CB-1:0]  s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic signed [DW-1:0]  s1_dax_q, s1_day_q, s1_dbx_q, s1_dby_q;
  logic                  s1_ab_q, s1_strad_q, s1_hit_q;
  logic signed [PW-1:0]  s2_p1_q, s2_p2_q;
  logic signed [DPW-1:0] s2_p3_q, s2_p4_q;
  logic                  s2_ab_q, s2_strad_q, s2_hit_q;
  logic signed [TW-1:0]  s3_term_q;
  logic signed [XW-1:0]  s3_cross_q;
  logic                  s3_ab_q, s3_strad_q, s3_hit_q;
  logic                  a_below, b_below;

  // A vertex counts as below when the query point precedes it in (x, y) order.
  assign a_below = (px_q < s0_ax_q) || ((px_q == s0_ax_q) && (py_q < s0_ay_q));
  assign b_below = (px_q < s0_bx_q) || ((px_q == s0_bx_q) && (py_q < s0_by_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q   <= 1'b0;
      first_q <= 1'b0;
      close_q <= 1'b0;
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
    end else begin
      rdv_q   <= cmd_i.rd_en;
      first_q <= cmd_i.rd_first;
      close_q <= cmd_i.close;
      s0_v_q  <= (rdv_q && !first_q) || close_q;
      s1_v_q  <= s0_v_q;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (rdv_q) begin
      vx_q <= rd_x;
      vy_q <= rd_y;
      if (first_q) begin
        fx_q <= rd_x;
        fy_q <= rd_y;
      end
    end
    // Edge from the previous vertex to the one just read, or the closing edge.
    s0_ax_q <= vx_q;
    s0_ay_q <= vy_q;
    s0_bx_q <= close_q ? fx_q : rd_x;
    s0_by_q <= close_q ? fy_q : rd_y;

    s1_ax_q    <= s0_ax_q;
    s1_ay_q    <= s0_ay_q;
    s1_bx_q    <= s0_bx_q;
    s1_by_q    <= s0_by_q;
    s1_dax_q   <= DW'(s0_ax_q) - DW'(px_q);
    s1_day_q   <= DW'(s0_ay_q) - DW'(py_q);
    s1_dbx_q   <= DW'(s0_bx_q) - DW'(px_q);
    s1_dby_q   <= DW'(s0_by_q) - DW'(py_q);
    s1_ab_q    <= a_below;
    s1_strad_q <= a_below != b_below;
    s1_hit_q   <= (s0_ax_q == px_q) && (s0_ay_q == py_q);

    s2_p1_q    <= s1_ax_q * s1_by_q;
    s2_p2_q    <= s1_ay_q * s1_bx_q;
    s2_p3_q    <= s1_dax_q * s1_dby_q;
    s2_p4_q    <= s1_day_q * s1_dbx_q;
    s2_ab_q    <= s1_ab_q;
    s2_strad_q <= s1_strad_q;
    s2_hit_q   <= s1_hit_q;

    s3_term_q  <= TW'(s2_p1_q) - TW'(s2_p2_q);
    s3_cross_q <= XW'(s2_p3_q) - XW'(s2_p4_q);
    s3_ab_q    <= s2_ab_q;
    s3_strad_q <= s2_strad_q;
    s3_hit_q   <= s2_hit_q;
  end

  // Accumulators.
  logic signed [ACC_W-1:0] sum_q;
  logic                    inside_q, blocked_q;
  logic                    cross_zero, cross_pos;

  assign cross_zero = (s3_cross_q == '0);
  assign cross_pos  = !s3_cross_q[XW-1] && !cross_zero;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      sum_q     <= '0;
      inside_q  <= 1'b0;
      blocked_q <= 1'b0;
    end else if (s3_v_q) begin
      sum_q     <= sum_q + ACC_W'(s3_term_q);
      blocked_q <= blocked_q || s3_hit_q || (s3_strad_q && cross_zero);
      if (s3_strad_q) begin
        inside_q <= inside_q ^ s3_ab_q ^ cross_pos;
      end
    end
  end

  assign stat_o.pipe_busy = rdv_q || close_q || s0_v_q || s1_v_q || s2_v_q || s3_v_q;

  // Result registers; the area saturates when the upper bits disagree.
  logic                    done_q;
  logic                    sum_ovf;
  logic signed [AREA_W-1:0] area_sat;

  assign sum_ovf  = !((sum_q[ACC_W-1:AREA_W-1] == '0) || (&sum_q[ACC_W-1:AREA_W-1]));
  assign area_sat = sum_ovf ? {sum_q[ACC_W-1], {(AREA_W-1){!sum_q[ACC_W-1]}}}
                            : sum_q[AREA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      inside_res_o <= inside_q && !blocked_q;
      twice_area_o <= area_sat;
      min_x_o      <= min_x_q;
      max_x_o      <= max_x_q;
      min_y_o      <= min_y_q;
      max_y_o      <= max_y_q;
    end
  end

  assign done_o = done_q;

  `PPIA_ASSERT(a_no_edge_clash, clk_i, rst_ni, !(rdv_q && close_q))
  `PPIA_ASSERT(a_done_after_drain, clk_i, rst_ni, done_q |-> !stat_o.pipe_busy)

endmodule

@@ rtl/core/polygon_point_inclusion_area.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon point inclusion and area
// Holds one polygon, answers point inclusion, twice the area and the box.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low. Clear and
// append keep busy low and return nothing. A query on a polygon of N
// vertices keeps busy high while it reads the N vertices, issues the closing
// edge, drains the edge pipeline and registers the result; on an empty
// polygon it only registers the result. The vertex memory gives one vertex a
// cycle and each edge then runs through a product and accumulate pipeline.
// The result is shown for one cycle with done_o high and cannot be held off,
// so the receiver must take it in that cycle. Appends beyond MAX_VERTICES are
// dropped.
module polygon_point_inclusion_area import ppia_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_W-1:0]              operation_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         done_o,
  output logic                         inside_res_o,
  output logic signed [AREA_W-1:0]     twice_area_o,
  output logic signed [COORD_BITS-1:0] min_x_o,
  output logic signed [COORD_BITS-1:0] max_x_o,
  output logic signed [COORD_BITS-1:0] min_y_o,
  output logic signed [COORD_BITS-1:0] max_y_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  ppia_cmd_t     cmd;
  ppia_stat_t    stat;
  logic [AW-1:0] addr;

  ppia_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .stat_i     (stat)
  );

  ppia_dp #(
    .COORD_BITS  (COORD_BITS),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .stat_o      (stat),
    .done_o      (done_o),
    .inside_res_o(inside_res_o),
    .twice_area_o(twice_area_o),
    .min_x_o     (min_x_o),
    .max_x_o     (max_x_o),
    .min_y_o     (min_y_o),
    .max_y_o     (max_y_o)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon point inclusion and area: testbench
// Sends clear, append and query words through the start/busy handshake with
// random gaps, keeps its own polygon and bounding box, and compares every
// query answer on done_o field by field against a pinned or worked-out answer.
// ----------------------------------------------------------------------------
module tb import ppia_pkg::*; ();

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned CW           = 16;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_WORDS = 1820;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint AREA_MAX = 64'sd549755813887;
  localparam longint AREA_MIN = -AREA_MAX - 1;

  typedef struct packed {
    logic                    in_flag;
    logic signed [AREA_W-1:0] area;
    logic signed [CW-1:0]    min_x;
    logic signed [CW-1:0]    max_x;
    logic signed [CW-1:0]    min_y;
    logic signed [CW-1:0]    max_y;
  } poly_answer_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 pinned;
    poly_answer_t         want;
  } stim_row_t;

  localparam poly_answer_t NO_ANSWER = '0;
  localparam poly_answer_t EMPTY_ANSWER =
    '{1'b0, 40'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
  // Full-range square, counterclockwise: twice the area is 2 * 65535^2.
  localparam poly_answer_t SQUARE_IN =
    '{1'b1, 40'sd8589672450, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
  localparam poly_answer_t SQUARE_OUT =
    '{1'b0, 40'sd8589672450, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};

  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{OP_QUERY,   16'sd5,     -16'sd7,    1'b1, EMPTY_ANSWER},
    '{OP_UNUSED,  16'sd1,     16'sd1,     1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sh8000,  16'sh8000,  1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sh7fff,  16'sh8000,  1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sh7fff,  16'sh7fff,  1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sh8000,  16'sh7fff,  1'b0, NO_ANSWER},
    '{OP_QUERY,   16'sd0,     16'sd0,     1'b1, SQUARE_IN},
    '{OP_QUERY,   16'sh7fff,  16'sh7fff,  1'b1, SQUARE_OUT},
    '{OP_QUERY,   16'sd0,     16'sh8000,  1'b1, SQUARE_OUT},
    '{OP_QUERY,   16'sh8000,  16'sd0,     1'b1, SQUARE_OUT},
    '{OP_QUERY,   16'sh8000,  16'sh8000,  1'b1, SQUARE_OUT},
    '{OP_CLEAR,   16'sd3,     16'sd4,     1'b0, NO_ANSWER},
    '{OP_QUERY,   16'sh7fff,  16'sh8000,  1'b1, EMPTY_ANSWER},
    '{OP_APPEND,  16'sd0,     16'sd0,     1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sd0,     16'sd10,    1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sd10,    16'sd0,     1'b0, NO_ANSWER},
    '{OP_QUERY,   16'sd2,     16'sd2,     1'b0, NO_ANSWER},
    '{OP_QUERY,   16'sd5,     16'sd5,     1'b0, NO_ANSWER},
    '{OP_QUERY,   -16'sd3,    16'sd4,     1'b0, NO_ANSWER},
    '{OP_QUERY,   16'sd0,     16'sd5,     1'b0, NO_ANSWER},
    '{OP_UNUSED,  16'sh7fff,  16'sh8000,  1'b0, NO_ANSWER},
    '{OP_APPEND,  16'sd10,    16'sd0,     1'b0, NO_ANSWER},
    '{OP_QUERY,   16'sd3,     16'sd3,     1'b0, NO_ANSWER},
    '{OP_CLEAR,   16'sd0,     16'sd0,     1'b0, NO_ANSWER},
    '{OP_APPEND,  -16'sd1,    -16'sd1,    1'b0, NO_ANSWER},
    '{OP_QUERY,   -16'sd1,    -16'sd1,    1'b0, NO_ANSWER}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic [OP_W-1:0]      operation_i = OP_CLEAR;
  logic signed [CW-1:0] coord_x_i   = '0;
  logic signed [CW-1:0] coord_y_i   = '0;
  logic                 busy;
  logic                 done_o;
  logic                 inside_res_o;
  logic signed [AREA_W-1:0] twice_area_o;
  logic signed [CW-1:0] min_x_o, max_x_o, min_y_o, max_y_o;

  // Typed answer for the word on the ports, driven along with it.
  logic         pin_valid  = 1'b0;
  poly_answer_t pin_answer = '0;

  // Predicted polygon.
  logic signed [CW-1:0] vert_x [MAX_VERTICES];
  logic signed [CW-1:0] vert_y [MAX_VERTICES];
  int                   vert_count;
  logic signed [CW-1:0] box_min_x, box_max_x, box_min_y, box_max_y;

  poly_answer_t answers_due [$];
  int           fails       = 0;
  int           cycle_count = 0;

  // The sender's view of the polygon, used to aim queries at vertices and edges.
  int shape_x [$];
  int shape_y [$];
  int lo_x, hi_x, lo_y, hi_y;
  int words_sent = 0;

  polygon_point_inclusion_area #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (CW)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .done_o      (done_o),
    .inside_res_o(inside_res_o),
    .twice_area_o(twice_area_o),
    .min_x_o     (min_x_o),
    .max_x_o     (max_x_o),
    .min_y_o     (min_y_o),
    .max_y_o     (max_y_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s at %0t ns: got %0d, expected %0d", what, $realtime, got, want);
    fails++;
  endtask

  function automatic void clear_shape();
    vert_count = 0;
    box_min_x  = 16'sh7fff;
    box_min_y  = 16'sh7fff;
    box_max_x  = 16'sh8000;
    box_max_y  = 16'sh8000;
  endfunction

  function automatic void apply_word(logic [OP_W-1:0] op, logic signed [CW-1:0] x,
                                     logic signed [CW-1:0] y);
    case (op)
      OP_CLEAR: begin
        clear_shape();
      end
      OP_APPEND: begin
        // A full store drops the vertex and leaves the box alone.
        if (vert_count < MAX_VERTICES) begin
          vert_x[vert_count] = x;
          vert_y[vert_count] = y;
          vert_count++;
          if (x < box_min_x) box_min_x = x;
          if (x > box_max_x) box_max_x = x;
          if (y < box_min_y) box_min_y = y;
          if (y > box_max_y) box_max_y = y;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Lexicographic order: the vertex lies beyond the query point in x, then y.
  function automatic bit lies_below(longint px, longint py, longint vx, longint vy);
    if (px != vx) return px < vx;
    return py < vy;
  endfunction

  function automatic poly_answer_t answer_query(logic signed [CW-1:0] qx,
                                                logic signed [CW-1:0] qy);
    poly_answer_t ans;
    bit           odd, blocked, ab, bb;
    longint       sum, c, ax, ay, bx, by, px, py;
    int           j;
    odd     = 1'b0;
    blocked = 1'b0;
    sum     = 0;
    px      = qx;
    py      = qy;
    for (int i = 0; i < vert_count; i++) begin
      j  = (i + 1 == vert_count) ? 0 : i + 1;
      ax = vert_x[i];
      ay = vert_y[i];
      bx = vert_x[j];
      by = vert_y[j];
      sum += ax * by - ay * bx;
      if (ax == px && ay == py) blocked = 1'b1;
      ab = lies_below(px, py, ax, ay);
      bb = lies_below(px, py, bx, by);
      if (ab != bb) begin
        c = (ax - px) * (by - py) - (ay - py) * (bx - px);
        if (c == 0) blocked = 1'b1;
        odd ^= ab ^ (c > 0);
      end
    end
    if (sum > AREA_MAX) sum = AREA_MAX;
    if (sum < AREA_MIN) sum = AREA_MIN;
    ans.in_flag = odd & ~blocked;
    ans.area    = sum[AREA_W-1:0];
    ans.min_x   = box_min_x;
    ans.max_x   = box_max_x;
    ans.min_y   = box_min_y;
    ans.max_y   = box_max_y;
    return ans;
  endfunction

  always @(posedge clk_i) begin : watch_ports
    poly_answer_t due;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        flag_mismatch("result with no query outstanding", 1, 0);
      end else begin
        due = answers_due.pop_front();
        if (inside_res_o !== due.in_flag)
          flag_mismatch("inside_res", longint'(inside_res_o), longint'(due.in_flag));
        if (twice_area_o !== due.area)
          flag_mismatch("twice_area", longint'(twice_area_o), longint'(due.area));
        if (min_x_o !== due.min_x)
          flag_mismatch("min_x", longint'(min_x_o), longint'(due.min_x));
        if (max_x_o !== due.max_x)
          flag_mismatch("max_x", longint'(max_x_o), longint'(due.max_x));
        if (min_y_o !== due.min_y)
          flag_mismatch("min_y", longint'(min_y_o), longint'(due.min_y));
        if (max_y_o !== due.max_y)
          flag_mismatch("max_y", longint'(max_y_o), longint'(due.max_y));
      end
    end
    if (rst_ni && start && !busy) begin
      if (operation_i == OP_QUERY)
        answers_due.push_back(pin_valid ? pin_answer : answer_query(coord_x_i, coord_y_i));
      else
        apply_word(operation_i, coord_x_i, coord_y_i);
    end
  end

  // Returns just after the edge that took the word; start stays high so that
  // a following word with no gap goes out back to back.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [CW-1:0] x,
                           input logic signed [CW-1:0] y, input int gap,
                           input logic pinned, input poly_answer_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    coord_x_i   <= x;
    coord_y_i   <= y;
    pin_valid   <= pinned;
    pin_answer  <= want;
    do @(posedge clk_i); while (busy);
    if (op == OP_CLEAR) begin
      shape_x.delete();
      shape_y.delete();
      lo_x = 32767;
      lo_y = 32767;
      hi_x = -32768;
      hi_y = -32768;
    end else if (op == OP_APPEND && shape_x.size() < MAX_VERTICES) begin
      shape_x.push_back(int'(x));
      shape_y.push_back(int'(y));
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
    end
  endtask

  task automatic settle_outstanding();
    start <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0:       return CW'($urandom_range(0, 40)) - 16'sd20;
      1:       return CW'($urandom_range(0, 2000)) - 16'sd1000;
      2:       return CW'($urandom());
      default: begin
        case ($urandom_range(0, 5))
          0:       return 16'sh8000;
          1:       return 16'sh8001;
          2:       return -16'sd1;
          3:       return 16'sd0;
          4:       return 16'sh7ffe;
          default: return 16'sh7fff;
        endcase
      end
    endcase
  endfunction

  // Word with a random gap, or none in a burst, now and then preceded by an unused opcode.
  task automatic put_word(input logic [OP_W-1:0] op, input logic signed [CW-1:0] x,
                          input logic signed [CW-1:0] y, input bit burst);
    if ($urandom_range(0, 29) == 0)
      send_word(OP_UNUSED, CW'($urandom()), CW'($urandom()),
                burst ? 0 : $urandom_range(0, 12), 1'b0, NO_ANSWER);
    send_word(op, x, y, burst ? 0 : $urandom_range(0, 12), 1'b0, NO_ANSWER);
    words_sent++;
  endtask

  initial begin
    bit                   burst;
    int                   mode, n, nq, kind, ns, e, f;
    logic signed [CW-1:0] qx, qy;
    clear_shape();
    lo_x = 32767;
    lo_y = 32767;
    hi_x = -32768;
    hi_y = -32768;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[k])
      send_word(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].x, DIRECTED_ROWS[k].y,
                $urandom_range(0, 12), DIRECTED_ROWS[k].pinned, DIRECTED_ROWS[k].want);
    // Hold off until the last answer is back.
    settle_outstanding();

    while (words_sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 9) < 3);
      mode  = $urandom_range(0, 3);
      if ($urandom_range(0, 9) != 0) put_word(OP_CLEAR, rand_coord(2), rand_coord(2), burst);
      // Mostly small polygons; now and then a large one that may overfill the store.
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      repeat (n) put_word(OP_APPEND, rand_coord(mode), rand_coord(mode), burst);
      nq = $urandom_range(1, 6);
      repeat (nq) begin
        kind = $urandom_range(0, 9);
        ns   = shape_x.size();
        if (ns == 0 || kind < 2) begin
          qx = rand_coord(mode);
          qy = rand_coord(mode);
        end else if (kind < 4) begin
          e  = $urandom_range(0, ns - 1);
          qx = CW'(shape_x[e]);
          qy = CW'(shape_y[e]);
        end else if (kind < 6) begin
          e  = $urandom_range(0, ns - 1);
          f  = (e + 1 == ns) ? 0 : e + 1;
          qx = CW'((shape_x[e] + shape_x[f]) / 2);
          qy = CW'((shape_y[e] + shape_y[f]) / 2);
        end else begin
          qx = CW'(lo_x + int'($urandom_range(0, hi_x - lo_x)));
          qy = CW'(lo_y + int'($urandom_range(0, hi_y - lo_y)));
        end
        put_word(OP_QUERY, qx, qy, burst);
      end
      if ($urandom_range(0, 19) == 0) settle_outstanding();
    end

    settle_outstanding();
    // Leave room for a stray late result.
    repeat (2 * MAX_VERTICES + 20) @(posedge clk_i);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
